/* rtl/core/ledtone_pkg.sv */
`timescale 1ns / 1ps

package ledtone_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int PERIOD_WIDTH = 16;
  localparam int CMP_WIDTH = (TIMER_WIDTH > PERIOD_WIDTH) ? TIMER_WIDTH : PERIOD_WIDTH;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int HALF_WIDTH = 8;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROTATE_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BLINK_PERIOD = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INITIAL_HALF = 2'd2;

  localparam logic [PERIOD_WIDTH-1:0] ROTATE_PERIOD_RESET = 16'd300;
  localparam logic [PERIOD_WIDTH-1:0] BLINK_PERIOD_RESET = 16'd1000;
  localparam logic [HALF_WIDTH-1:0] HALF_PERIOD_RESET = 8'd8;
  localparam logic [HALF_WIDTH-1:0] HALF_PERIOD_MIN = 8'd2;
  localparam logic [HALF_WIDTH-1:0] HALF_PERIOD_MAX = 8'hFF;

  typedef enum logic [1:0] {
    ROT_START = 2'd0,
    ROT_FIRST = 2'd1,
    ROT_SECOND = 2'd2,
    ROT_THIRD = 2'd3
  } rotate_phase_t;

  typedef enum logic [2:0] {
    TONE_START = 3'd0,
    TONE_ON = 3'd1,
    TONE_OFF = 3'd2,
    TONE_RAISE = 3'd3,
    TONE_LOWER = 3'd4
  } tone_phase_t;

  typedef struct packed {
    logic fire;
    logic up;
    logic down;
    logic snd;
    logic load;
    logic [HALF_WIDTH-1:0] load_value;
  } tone_ctrl_t;

endpackage

/* rtl/core/ledtone_if.sv */
`timescale 1ns / 1ps

interface ledtone_in_if;
  logic valid;
  logic ready;
  logic btn_up;
  logic btn_down;
  logic sound_enable;

  modport source (output valid, output btn_up, output btn_down, output sound_enable,
                  input ready);
  modport sink (input valid, input btn_up, input btn_down, input sound_enable,
                output ready);
endinterface

interface ledtone_out_if;
  logic valid;
  logic ready;
  logic [7:0] port_value;

  modport source (output valid, output port_value, input ready);
  modport sink (input valid, input port_value, output ready);
endinterface

/* rtl/core/ledtone_tone.sv */
`timescale 1ns / 1ps

module ledtone_tone (
  input  logic                   clk,
  input  logic                   rst,
  input  ledtone_pkg::tone_ctrl_t ctrl,
  output logic                   tone_bit
);
  import ledtone_pkg::*;

  tone_phase_t phase, phase_next;
  logic [HALF_WIDTH-1:0] count, count_next, count_mid;
  logic [HALF_WIDTH-1:0] limit, limit_next;
  logic bit_next;
  logic below;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= TONE_START;
      count <= HALF_WIDTH'(1);
      limit <= HALF_PERIOD_RESET;
      tone_bit <= 1'b0;
    end else begin
      if (ctrl.fire) begin
        phase <= phase_next;
        count <= count_next;
        tone_bit <= bit_next;
      end
      // A write of the initial half-period reloads the limit right away.
      if (ctrl.load) begin
        limit <= ctrl.load_value;
      end else if (ctrl.fire) begin
        limit <= limit_next;
      end
    end
  end

  always_comb begin
    below = count < limit;
    phase_next = phase;
    count_mid = count;
    limit_next = limit;
    unique case (phase)
      TONE_START: phase_next = TONE_ON;
      TONE_ON: begin
        if (below) begin
          phase_next = ctrl.up ? TONE_RAISE : TONE_ON;
        end else begin
          phase_next = TONE_OFF;
          count_mid = '0;
        end
      end
      TONE_RAISE: begin
        if (!ctrl.up) begin
          count_mid = '0;
          if (limit > HALF_PERIOD_MIN) limit_next = limit - HALF_WIDTH'(1);
          phase_next = TONE_OFF;
        end
      end
      TONE_OFF: begin
        if (below) begin
          phase_next = ctrl.down ? TONE_LOWER : TONE_OFF;
        end else begin
          phase_next = TONE_ON;
          count_mid = '0;
        end
      end
      TONE_LOWER: begin
        if (!ctrl.down) begin
          count_mid = '0;
          if (limit < HALF_PERIOD_MAX) limit_next = limit + HALF_WIDTH'(1);
          phase_next = TONE_ON;
        end
      end
      default: phase_next = TONE_ON;
    endcase

    count_next = count_mid;
    bit_next = tone_bit;
    if (phase_next == TONE_ON) begin
      if (ctrl.snd) bit_next = 1'b1;
      count_next = count_mid + HALF_WIDTH'(1);
    end else if (phase_next == TONE_OFF) begin
      count_next = count_mid + HALF_WIDTH'(1);
      bit_next = 1'b0;
    end
  end

endmodule

/* rtl/core/led_sequencer_and_tone_generator.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                          Request moves when
// in_ch     in   btn_up, btn_down, sound_enable   valid && ready
// out_ch    out  port_value[7:0]                  valid && ready
// cfg       in   cfg_index, cfg_data              cfg_we
//
// One tick per cycle unless the output stalls: the whole tick update runs in
// the accept cycle, the port byte is written to the output register at the
// accepting edge and is offered from the next cycle on.
// The input is ready whenever the output register is empty or being drained.
// Synchronous reset loads the register defaults and resets all tick state.

module led_sequencer_and_tone_generator (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [ledtone_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [ledtone_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  ledtone_in_if.sink                               in_ch,
  ledtone_out_if.source                            out_ch
);
  import ledtone_pkg::*;

  logic [PERIOD_WIDTH-1:0] rotate_period, blink_period;
  logic [TIMER_WIDTH-1:0] rotate_elapsed, rotate_elapsed_next;
  logic [TIMER_WIDTH-1:0] blink_elapsed, blink_elapsed_next;
  logic started;
  rotate_phase_t rotate_phase, rotate_phase_next;
  logic [2:0] rotate_leds, rotate_leds_next;
  logic blink_on, blink_on_next;
  logic [7:0] port_reg, port_next;
  logic out_valid;
  logic tone_bit;
  logic accept, rotate_fire, blink_fire;
  tone_ctrl_t tone_ctrl;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.port_value = port_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_period <= ROTATE_PERIOD_RESET;
      blink_period <= BLINK_PERIOD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROTATE_PERIOD) rotate_period <= cfg_data;
      if (cfg_index == CFG_BLINK_PERIOD) blink_period <= cfg_data;
    end
  end

  always_comb begin
    rotate_fire = CMP_WIDTH'(rotate_elapsed) >= CMP_WIDTH'(rotate_period);
    blink_fire = CMP_WIDTH'(blink_elapsed) >= CMP_WIDTH'(blink_period);

    // Firing clears the count, and the tick then counts as one.
    if (rotate_fire) rotate_elapsed_next = TIMER_WIDTH'(1);
    else if (rotate_elapsed != '1) rotate_elapsed_next = rotate_elapsed + TIMER_WIDTH'(1);
    else rotate_elapsed_next = rotate_elapsed;
    if (blink_fire) blink_elapsed_next = TIMER_WIDTH'(1);
    else if (blink_elapsed != '1) blink_elapsed_next = blink_elapsed + TIMER_WIDTH'(1);
    else blink_elapsed_next = blink_elapsed;

    rotate_phase_next = rotate_phase;
    rotate_leds_next = rotate_leds;
    if (rotate_fire) begin
      unique case (rotate_phase)
        ROT_FIRST: begin
          rotate_phase_next = ROT_SECOND;
          rotate_leds_next = 3'b010;
        end
        ROT_SECOND: begin
          rotate_phase_next = ROT_THIRD;
          rotate_leds_next = 3'b100;
        end
        default: begin
          rotate_phase_next = ROT_FIRST;
          rotate_leds_next = 3'b001;
        end
      endcase
    end

    blink_on_next = blink_on;
    if (blink_fire) blink_on_next = !blink_on;

    // The combiner runs ahead of the tone task, so it sees last tick's tone bit.
    port_next = port_reg;
    if (started) port_next = {3'b000, tone_bit, blink_on_next, rotate_leds_next};

    tone_ctrl.fire = accept && started;
    tone_ctrl.up = in_ch.btn_up;
    tone_ctrl.down = in_ch.btn_down;
    tone_ctrl.snd = in_ch.sound_enable;
    tone_ctrl.load = cfg_we && (cfg_index == CFG_INITIAL_HALF);
    tone_ctrl.load_value = cfg_data[HALF_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_elapsed <= '0;
      blink_elapsed <= '0;
      started <= 1'b0;
      rotate_phase <= ROT_START;
      rotate_leds <= '0;
      blink_on <= 1'b0;
      port_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        rotate_elapsed <= rotate_elapsed_next;
        blink_elapsed <= blink_elapsed_next;
        started <= 1'b1;
        rotate_phase <= rotate_phase_next;
        rotate_leds <= rotate_leds_next;
        blink_on <= blink_on_next;
        port_reg <= port_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  ledtone_tone u_tone (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (tone_ctrl),
    .tone_bit (tone_bit)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.valid)
    else $error("accepted tick produced no result");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input ready while result is stalled");

  a_rotator_onehot: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> $onehot0(out_ch.port_value[2:0]))
    else $error("more than one rotator LED lit");

  a_upper_bits_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.port_value[7:5] == 3'b000))
    else $error("unused port bits set");

endmodule
